// ----- src/rslk_pkg.sv -----
// ----------------------------------------------------------------------------
// rslk_pkg
// Shared types and constants for the RS-485 link detect and hold timer.
// ----------------------------------------------------------------------------
package rslk_pkg;

    localparam int CNT_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int TDATA_W   = 8;

    localparam logic [CNT_W-1:0] HOLD_MARGIN     = 16'd100;
    localparam logic [CNT_W-1:0] CNT_MAX         = 16'hFFFF;
    localparam logic [CNT_W-1:0] SETTLE_RST      = 16'd1000;
    localparam logic             NONSTD_RST      = 1'b0;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NONSTD_LEVEL = 2'd1;

    typedef struct packed {
        logic restart_settle;
        logic transmitting;
        logic master_mode;
        logic sense_level;
    } tick_t;

    typedef struct packed {
        logic hold_ready;
        logic link_latched_now;
        logic link_nonstandard;
    } result_t;

    typedef struct packed {
        logic                 wr_en;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DAT_W-1:0] data;
    } cfg_wr_t;

endpackage

// ----- src/rslk_core.sv -----
// ----------------------------------------------------------------------------
// rslk_core
// Link state, hold timer and configuration registers; one tick per enable.
// ----------------------------------------------------------------------------
module rslk_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  rslk_pkg::cfg_wr_t cfg,
    input  logic             step_en,
    input  rslk_pkg::tick_t  tick,
    output rslk_pkg::result_t result
);
    import rslk_pkg::*;

    logic [CNT_W-1:0] settle_ticks_reg;
    logic             nonstd_level_reg;

    logic             last_level_reg,   last_level_next;
    logic [CNT_W-1:0] settle_count_reg, settle_count_next;
    logic             link_kind_reg,    link_kind_next;
    logic             hold_flag_reg,    hold_flag_next;
    logic [CNT_W-1:0] hold_count_reg,   hold_count_next;
    logic             last_mode_reg,    last_mode_next;
    logic             latched;

    logic [CNT_W:0]   tx_sum;
    logic [CNT_W-1:0] tx_lim;
    logic [CNT_W-1:0] rx_lim;

    // hold limits, saturated at both ends
    assign tx_sum = {1'b0, settle_ticks_reg} + {1'b0, HOLD_MARGIN};
    assign tx_lim = tx_sum[CNT_W] ? CNT_MAX : tx_sum[CNT_W-1:0];
    assign rx_lim = (settle_ticks_reg < HOLD_MARGIN) ? '0 : settle_ticks_reg - HOLD_MARGIN;

    always_comb begin
        last_level_next   = last_level_reg;
        settle_count_next = settle_count_reg;
        link_kind_next    = link_kind_reg;
        hold_flag_next    = hold_flag_reg;
        hold_count_next   = hold_count_reg;
        last_mode_next    = tick.master_mode;
        latched           = 1'b0;

        if (tick.restart_settle || (tick.master_mode != last_mode_reg)) begin
            settle_count_next = '0;
        end

        if (!tick.master_mode) begin
            if (tick.sense_level != last_level_reg) begin
                settle_count_next = '0;
                last_level_next   = tick.sense_level;
            end
            if (settle_count_next < settle_ticks_reg) begin
                settle_count_next = settle_count_next + 1'b1;
                if (settle_count_next >= settle_ticks_reg) begin
                    link_kind_next = (tick.sense_level == nonstd_level_reg);
                    latched        = 1'b1;
                end
            end
            hold_flag_next  = 1'b0;
            hold_count_next = '0;
        end else if (!tick.transmitting) begin
            if (hold_flag_reg) begin
                if (hold_count_reg < rx_lim) begin
                    hold_count_next = hold_count_reg + 1'b1;
                end else begin
                    hold_flag_next  = 1'b0;
                    hold_count_next = '0;
                end
            end else begin
                hold_count_next = '0;
            end
        end else begin
            if (!hold_flag_reg) begin
                if (hold_count_reg < tx_lim) begin
                    hold_count_next = hold_count_reg + 1'b1;
                end else begin
                    hold_flag_next  = 1'b1;
                    hold_count_next = '0;
                end
            end else begin
                hold_count_next = '0;
            end
        end
    end

    assign result.link_nonstandard = link_kind_next;
    assign result.link_latched_now = latched;
    assign result.hold_ready       = hold_flag_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_ticks_reg <= SETTLE_RST;
            nonstd_level_reg <= NONSTD_RST;
        end else if (cfg.wr_en) begin
            case (cfg.index)
                CFG_SETTLE_TICKS: settle_ticks_reg <= cfg.data[CNT_W-1:0];
                CFG_NONSTD_LEVEL: nonstd_level_reg <= cfg.data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_level_reg   <= 1'b0;
            settle_count_reg <= '0;
            link_kind_reg    <= 1'b0;
            hold_flag_reg    <= 1'b0;
            hold_count_reg   <= '0;
            last_mode_reg    <= 1'b0;
        end else if (step_en) begin
            last_level_reg   <= last_level_next;
            settle_count_reg <= settle_count_next;
            link_kind_reg    <= link_kind_next;
            hold_flag_reg    <= hold_flag_next;
            hold_count_reg   <= hold_count_next;
            last_mode_reg    <= last_mode_next;
        end
    end

endmodule

// ----- src/rs485_link_detect_and_hold_timer.sv -----
// ----------------------------------------------------------------------------
// rs485_link_detect_and_hold_timer
// RS-485 connection-sense debounce, link kind latch and master hold timer.
// ----------------------------------------------------------------------------
// Each request on the slave stream is one timer tick; each tick yields exactly
// one result on the master stream. A tick is taken into an input register,
// the link and hold state is updated by a single pass of counter and compare
// logic, and the result lands in an output register. The block takes one
// tick per clock cycle while the result stream does not stall. A tick
// passes the input register, then the output register, before its result
// is valid. The input side stays ready while a result waits, as long as
// the input register can move forward in the same cycle. Write settle_ticks
// and nonstd_level only while no tick is in flight.
// ----------------------------------------------------------------------------
module rs485_link_detect_and_hold_timer (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [rslk_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  logic [rslk_pkg::CFG_DAT_W-1:0]    cfg_wr_data,
    // tick stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [0] sense_level, [1] master_mode, [2] transmitting, [3] restart_settle
    input  logic [rslk_pkg::TDATA_W-1:0]      s_tdata,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] link_nonstandard, [1] link_latched_now, [2] hold_ready
    output logic [rslk_pkg::TDATA_W-1:0]      m_tdata
);
    import rslk_pkg::*;

    logic    in_valid_reg;
    tick_t   in_tick_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t step_res;
    cfg_wr_t cfg;
    logic    advance;

    // Move the held tick into the result register when that slot is free
    // or drains this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign cfg.wr_en = cfg_wr_en;
    assign cfg.index = cfg_wr_index;
    assign cfg.data  = cfg_wr_data;

    // Hold the accepted tick until it can advance.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_tick_reg <= s_tdata[$bits(tick_t)-1:0];
        end
    end

    // State update commits only when the tick advances.
    rslk_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step_en (advance),
        .tick    (in_tick_reg),
        .result  (step_res)
    );

    // Result register: drop on take, load on advance.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_W-$bits(result_t)){1'b0}}, out_res_reg};

endmodule
